>>> hdl/edb_pkg.sv
// Shared constants, types and helpers for the edge-gated detail boost block.
`timescale 1ns / 1ps
`default_nettype none

package edb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int WIN_SIZE       = 5;   // rows covered by one mark column
  localparam int WIN_COLS       = 4;   // previous columns held in the cell chain
  localparam int HIST_W         = WIN_SIZE - 1;
  localparam int CELL_ONES_W    = 3;   // enough for a count of 0..5
  localparam int WIN_ONES_W     = 5;   // enough for a count of 0..25
  localparam int EDGE_COUNT_MIN = 13;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = 2;
  localparam int FIFO_CNT_W     = 3;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int THRESHOLD_W    = 8;
  localparam int GAIN_W         = 6;
  localparam int PIXEL_W        = 8;
  localparam int DETAIL_W       = 9;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DIFF_THRESHOLD = 2'd2,
    REG_DETAIL_GAIN    = 2'd3
  } cfg_reg_t;

  localparam logic [FRAME_WIDTH_W-1:0]  RST_FRAME_WIDTH    = 11'd1024;
  localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT   = 16'd1024;
  localparam logic [THRESHOLD_W-1:0]    RST_DIFF_THRESHOLD = 8'd0;
  localparam logic [GAIN_W-1:0]         RST_DETAIL_GAIN    = 6'd1;

  function automatic logic [CELL_ONES_W-1:0] ones_in_column(
    input logic [WIN_SIZE-1:0] bits
  );
    logic [CELL_ONES_W-1:0] n;
    n = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      n = n + CELL_ONES_W'(bits[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/edb_cell.sv
// One window cell: holds a 5-row mark column and passes it to its neighbor.
`timescale 1ns / 1ps
`default_nettype none

module edb_cell
  import edb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   shift_en,
  input  wire logic                   clear,
  input  wire logic [WIN_SIZE-1:0]    col_in,
  output      logic [WIN_SIZE-1:0]    col_out,
  output      logic [CELL_ONES_W-1:0] ones
);

  logic [WIN_SIZE-1:0] held;

  // start of a row: the window left of column zero is empty
  assign col_out = clear ? '0 : held;
  assign ones    = ones_in_column(col_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (shift_en) begin
      held <= col_in;
    end
  end

endmodule

`default_nettype wire

>>> hdl/edge_gated_detail_boost_core.sv
// Edge-gated detail boost: top level with line store, cell chain and output queue.
//
// One pixel per clock in raster order while the queue has room; one result per pixel.
// An accepted pixel reads its column of the 4-bit mark line store (one read and
// one write port, the read registered) and reaches the result stage in the next
// cycle, where the window count is formed from the line-store column and a chain
// of four cells holding the previous columns; the result is written to the queue
// from that stage. A 4-entry output queue lets the input keep flowing while a
// result waits; with results taken every cycle the rate is one pixel per clock.
// Configuration writes are taken at any time and should occur only while idle.
// The line store needs no clearing after reset: rows above the frame top are masked.
`timescale 1ns / 1ps
`default_nettype none

module edge_gated_detail_boost_core
  import edb_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [PIXEL_W-1:0]            smooth_pixel,
  input  wire logic [PIXEL_W-1:0]            smoother_pixel,
  input  wire logic [PIXEL_W-1:0]            median_pixel,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [PIXEL_W-1:0]            output_pixel,
  output      logic signed [DETAIL_W-1:0]    detail,
  output      logic                          edge_flag
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > FRAME_WIDTH_W) ? CW + 1 : FRAME_WIDTH_W;

  typedef struct packed {
    logic [PIXEL_W-1:0]         pixel;
    logic signed [DETAIL_W-1:0] detail;
    logic                       flag;
  } out_item_t;

  // configuration registers
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [THRESHOLD_W-1:0]    diff_threshold;
  logic [GAIN_W-1:0]         detail_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      diff_threshold <= RST_DIFF_THRESHOLD;
      detail_gain    <= RST_DETAIL_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[FRAME_HEIGHT_W-1:0];
        REG_DIFF_THRESHOLD: diff_threshold <= cfg_data[THRESHOLD_W-1:0];
        REG_DETAIL_GAIN:    detail_gain    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- accept stage
  logic                  in_fire;
  logic [CW-1:0]         col_pos;
  logic [FRAME_HEIGHT_W-1:0] row_pos;
  logic [WW-1:0]         act_width;
  logic [WW-1:0]         col_plus;
  logic [FRAME_HEIGHT_W:0] row_plus;
  logic [FRAME_HEIGHT_W-1:0] row_next;
  logic signed [DETAIL_W:0]  diff_w;
  logic signed [DETAIL_W:0]  thr_w;
  logic                  mark;
  logic [HIST_W-1:0]     row_mask;

  assign in_fire = in_valid && in_ready;

  assign act_width = (frame_width == '0 || WW'(frame_width) > WW'(MAX_WIDTH))
                   ? WW'(MAX_WIDTH) : WW'(frame_width);
  assign col_plus  = WW'(col_pos) + WW'(1);
  assign row_plus  = {1'b0, row_pos} + (FRAME_HEIGHT_W+1)'(1);

  always_comb begin
    row_next = row_plus[FRAME_HEIGHT_W-1:0];
    if (frame_height != '0 && row_plus >= {1'b0, frame_height}) begin
      row_next = '0;
    end
  end

  assign diff_w = $signed({2'b00, smooth_pixel}) - $signed({2'b00, smoother_pixel});
  assign thr_w  = $signed({2'b00, diff_threshold});
  assign mark   = (diff_w > thr_w) || (diff_w < -thr_w);

  // rows above the frame top do not count
  always_comb begin
    if (row_pos >= FRAME_HEIGHT_W'(HIST_W)) begin
      row_mask = '1;
    end else begin
      case (row_pos[1:0])
        2'd0:    row_mask = 4'b0000;
        2'd1:    row_mask = 4'b0001;
        2'd2:    row_mask = 4'b0011;
        default: row_mask = 4'b0111;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_fire) begin
      if (col_plus >= act_width) begin
        col_pos <= '0;
        row_pos <= row_next;
      end else begin
        col_pos <= col_plus[CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- result stage
  logic                       s1_valid;
  logic signed [DETAIL_W-1:0] s1_diff;
  logic                       s1_mark;
  logic [PIXEL_W-1:0]         s1_median;
  logic [HIST_W-1:0]          s1_row_mask;
  logic                       s1_col_zero;
  logic [CW-1:0]              s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_diff     <= diff_w[DETAIL_W-1:0];
      s1_mark     <= mark;
      s1_median   <= median_pixel;
      s1_row_mask <= row_mask;
      s1_col_zero <= (col_pos == '0);
      s1_col      <= col_pos;
    end
  end

  // mark line store; a write to the column being read is passed straight through
  logic [HIST_W-1:0]   line_mem [MAX_WIDTH];
  logic [HIST_W-1:0]   rd_hist;
  logic [WIN_SIZE-1:0] cur_col;

  assign cur_col = {rd_hist & s1_row_mask, s1_mark};

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= cur_col[HIST_W-1:0];
    end
    if (in_fire) begin
      if (s1_valid && s1_col == col_pos) begin
        rd_hist <= cur_col[HIST_W-1:0];
      end else begin
        rd_hist <= line_mem[col_pos];
      end
    end
  end

  // cell chain of previous columns
  logic [WIN_SIZE-1:0]    link [WIN_COLS+1];
  logic [CELL_ONES_W-1:0] cell_ones [WIN_COLS];

  assign link[0] = cur_col;

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    edb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (s1_valid),
      .clear    (s1_col_zero),
      .col_in   (link[k]),
      .col_out  (link[k+1]),
      .ones     (cell_ones[k])
    );
  end

  logic [WIN_ONES_W-1:0]       win_count;
  logic                        flag;
  logic signed [DETAIL_W-1:0]  gated;
  logic signed [PIXEL_W+DETAIL_W:0] product;
  logic signed [PIXEL_W+DETAIL_W:0] boosted;
  logic [PIXEL_W-1:0]          pixel;

  always_comb begin
    win_count = WIN_ONES_W'(ones_in_column(cur_col));
    for (int k = 0; k < WIN_COLS; k++) begin
      win_count = win_count + WIN_ONES_W'(cell_ones[k]);
    end
  end

  assign flag    = win_count >= WIN_ONES_W'(EDGE_COUNT_MIN);
  assign gated   = (s1_mark && flag) ? s1_diff : '0;
  assign product = (PIXEL_W+DETAIL_W+1)'($signed({1'b0, detail_gain}) * gated);
  assign boosted = product + $signed({{(DETAIL_W+1){1'b0}}, s1_median});

  always_comb begin
    if (boosted < 0) begin
      pixel = '0;
    end else if (boosted > $signed((PIXEL_W+DETAIL_W+1)'(255))) begin
      pixel = '1;
    end else begin
      pixel = boosted[PIXEL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- output queue
  out_item_t             fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] occ;
  logic                  pop;
  logic [FIFO_CNT_W:0]   pending;

  assign pop       = out_valid && out_ready;
  assign out_valid = (occ != '0);
  assign pending   = {1'b0, occ} + (FIFO_CNT_W+1)'(s1_valid);
  assign in_ready  = pending < (FIFO_CNT_W+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fifo_mem[wr_ptr] <= '{pixel: pixel, detail: gated, flag: flag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      occ <= occ + FIFO_CNT_W'(s1_valid) - FIFO_CNT_W'(pop);
    end
  end

  assign output_pixel = fifo_mem[rd_ptr].pixel;
  assign detail       = fifo_mem[rd_ptr].detail;
  assign edge_flag    = fifo_mem[rd_ptr].flag;

  // ---------------------------------------------------------------- checks
  a_accept_reaches_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted request did not reach the result stage");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(in_fire))
    else $error("result stage valid without an accepted request");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_detail_needs_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && detail != '0) |-> edge_flag)
    else $error("detail passed without edge flag");

endmodule

`default_nettype wire
